// File: design/ffsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, codes and helpers for the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned DEF_MAX_CHUNKS = 64;
  localparam logic [31:0] RESET_BLOCK_BYTES = 32'd268435456;
  localparam int unsigned OW = 35;  // offset math width, covers double align-up

  localparam logic [0:0] CFG_BLOCK_BYTES = 1'b0;
  localparam logic [0:0] CFG_PAGE_GRAN   = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [0:0] REQ_ALLOC = 1'b0;
  localparam logic [0:0] REQ_FREE  = 1'b1;

  localparam logic [2:0] KIND_FREE    = 3'd0;
  localparam logic [2:0] KIND_BUFFER  = 3'd1;
  localparam logic [2:0] KIND_IMAGE   = 3'd2;
  localparam logic [2:0] KIND_LINEAR  = 3'd3;
  localparam logic [2:0] KIND_OPTIMAL = 3'd4;

  typedef enum logic [2:0] {
    COP_NONE,
    COP_RESET,
    COP_ALLOC,
    COP_MARK,
    COP_REMOVE
  } cop_t;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] size;
    logic [2:0]  kind;
    logic [31:0] tag;
  } entry_t;

  // broadcast to every cell for a table update
  typedef struct packed {
    cop_t        op;
    logic [31:0] bb;       // new block size on reset
    logic [31:0] need;
    logic [2:0]  kind;
    logic        split;
    logic [31:0] new_off;
    logic [31:0] rem;
    logic [31:0] new_tag;
  } ctl_t;

  // request terms every cell uses for the fit test
  typedef struct packed {
    logic [31:0] amask;
    logic [31:0] bytes;
    logic [2:0]  kind;
    logic [20:0] gmask;
    logic        gran_en;
  } req_t;

  // power-of-two floor minus one; zero maps to zero (floor of 1)
  function automatic logic [31:0] pow2_mask(input logic [31:0] v);
    logic [31:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s >> 1;
  endfunction

  function automatic logic kinds_conflict(input logic [2:0] a, input logic [2:0] b);
    logic [2:0] lo;
    logic [2:0] hi;
    logic       r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case (lo)
      KIND_BUFFER:  r = (hi == KIND_IMAGE) || (hi == KIND_OPTIMAL);
      KIND_IMAGE:   r = (hi == KIND_IMAGE) || (hi == KIND_LINEAR) || (hi == KIND_OPTIMAL);
      KIND_LINEAR:  r = (hi == KIND_OPTIMAL);
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/ffsa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_cell
// One table entry: holds a chunk, runs a four-stage fit test and shifts
// to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module ffsa_cell #(
  parameter int unsigned MAX_CHUNKS = ffsa_pkg::DEF_MAX_CHUNKS,
  parameter int unsigned INDEX      = 0
) (
  input  wire                                clk,
  input  wire ffsa_pkg::ctl_t                ctl,
  input  wire [$clog2(MAX_CHUNKS)-1:0]       idx,
  input  wire [$clog2(MAX_CHUNKS+1)-1:0]     count,
  input  wire ffsa_pkg::req_t                req,
  input  wire ffsa_pkg::entry_t              prev_ent,
  input  wire ffsa_pkg::entry_t              next_ent,
  output ffsa_pkg::entry_t                   ent,
  output logic                               fit,
  output logic [31:0]                        need,
  output logic [31:0]                        aoff
);
  import ffsa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_CHUNKS);
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [IW:0] J = INDEX[IW:0];
  localparam logic [CW-1:0] JC = CW'(INDEX);
  localparam logic [CW-1:0] JN = CW'(INDEX + 1);

  entry_t ent_r;
  logic [OW-1:0] o1_r, o1g_r, o_r, need_r;
  logic          pconf_r, sp_r, fit_r;

  logic [OW-1:0] s35, am35, gm35, bytes35, nxt35, o_sel, end35;
  logic          valid, has_next;
  logic [IW:0]   idx_w;

  assign idx_w    = {1'b0, idx};
  assign valid    = (JC < count);
  assign has_next = (JN < count);
  assign s35      = {3'b0, ent_r.off};
  assign am35     = {3'b0, req.amask};
  assign gm35     = {14'b0, req.gmask};
  assign bytes35  = {3'b0, req.bytes};
  assign nxt35    = {3'b0, next_ent.off};
  assign o_sel    = (pconf_r && sp_r) ? o1g_r : o1_r;
  assign end35    = o_r + bytes35 - 1'b1;

  // fit test pipeline
  always_ff @(posedge clk) begin
    o1_r    <= (s35 + am35) & ~am35;
    pconf_r <= (INDEX > 0) && req.gran_en && kinds_conflict(prev_ent.kind, req.kind);
    o1g_r   <= (o1_r + gm35) & ~gm35;
    sp_r    <= ((s35 - 1'b1) & ~gm35) == (o1_r & ~gm35);
    o_r     <= o_sel;
    need_r  <= o_sel - s35 + bytes35;
    fit_r   <= valid && (ent_r.kind == KIND_FREE) && (need_r <= {3'b0, ent_r.size}) &&
               !(req.gran_en && has_next && kinds_conflict(req.kind, next_ent.kind) &&
                 ((end35 & ~gm35) == (nxt35 & ~gm35)));
  end

  // table update
  always_ff @(posedge clk) begin
    case (ctl.op)
      COP_RESET: begin
        if (INDEX == 0) begin
          ent_r.off  <= '0;
          ent_r.size <= ctl.bb;
          ent_r.kind <= KIND_FREE;
          ent_r.tag  <= '0;
        end
      end
      COP_ALLOC: begin
        if (J == idx_w) begin
          ent_r.size <= ctl.need;
          ent_r.kind <= ctl.kind;
        end else if (ctl.split && (J == idx_w + 1'b1)) begin
          ent_r.off  <= ctl.new_off;
          ent_r.size <= ctl.rem;
          ent_r.kind <= KIND_FREE;
          ent_r.tag  <= ctl.new_tag;
        end else if (ctl.split && (J > idx_w + 1'b1)) begin
          ent_r <= prev_ent;
        end
      end
      COP_MARK: begin
        if (J == idx_w) ent_r.kind <= KIND_FREE;
      end
      COP_REMOVE: begin
        if (J + 1'b1 == idx_w) ent_r.size <= ent_r.size + next_ent.size;
        else if (J >= idx_w) ent_r <= next_ent;
      end
      default: ;
    endcase
  end

  assign ent  = ent_r;
  assign fit  = fit_r;
  assign need = need_r[31:0];
  assign aoff = o_r[31:0];

endmodule
`default_nettype wire

// File: design/first_fit_segment_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// First-fit chunk allocator with coalescing, built as a row of table cells.
// ----------------------------------------------------------------------------
// Allocate: a 4-stage fit test in every cell, a priority pick, a commit,
//   then the result load.
// Free: id search, mark free, merge left, merge right, result; an unknown
//   id skips the merges and goes straight to the result.
// One transaction at a time; the next one is taken the cycle after the
//   result load, and a finished result may wait in the output register.
// Reset (synchronous, rst_n low): one free chunk of 268435456 bytes,
//   next id 1, nothing in use, granularity 1.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit #(
  parameter int unsigned MAX_CHUNKS = ffsa_pkg::DEF_MAX_CHUNKS
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_req_type,
  input  wire [31:0] in_req_bytes,
  input  wire [31:0] in_req_align,
  input  wire [2:0]  in_resource_kind,
  input  wire [31:0] in_free_id,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [1:0] out_status,
  output logic [31:0] out_alloc_id,
  output logic [31:0] out_alloc_offset,
  output logic [31:0] out_used_bytes,
  input  wire        cfg_we,
  input  wire [0:0]  cfg_index,
  input  wire [31:0] cfg_wdata
);
  import ffsa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_CHUNKS);
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [CW-1:0] MAXC = MAX_CHUNKS[CW-1:0];

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_A1      = 12'b000000000010,
    S_A2      = 12'b000000000100,
    S_A3      = 12'b000000001000,
    S_A4      = 12'b000000010000,
    S_PICK    = 12'b000000100000,
    S_ACOMMIT = 12'b000001000000,
    S_FFIND   = 12'b000010000000,
    S_FMARK   = 12'b000100000000,
    S_FMERGEP = 12'b001000000000,
    S_FMERGEN = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   next_tag_r, next_tag_nxt;
  logic [31:0]   bytes_r, bytes_nxt;
  logic [20:0]   gmask_r;
  logic [31:0]   gmask_w;
  req_t          req_r;
  logic          bad_r;
  logic [31:0]   free_id_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;

  // pending result
  logic [1:0]    rs_status_r, rs_status_nxt;
  logic [31:0]   rs_id_r, rs_id_nxt;
  logic [31:0]   rs_off_r, rs_off_nxt;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_id_r, out_off_r, out_used_r;

  ctl_t          ctl;
  logic [IW-1:0] cidx;

  entry_t        ent [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0] fit_v, match_v;
  logic [31:0]   need_v [MAX_CHUNKS];
  logic [31:0]   aoff_v [MAX_CHUNKS];

  logic          in_acc;
  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // granularity page mask from the written value
  assign gmask_w = pow2_mask({11'b0, cfg_wdata[20:0]});

  // cell row
  for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
    entry_t pe, ne;
    if (g == 0) begin : g_first
      assign pe = '0;
    end else begin : g_mid
      assign pe = ent[g-1];
    end
    if (g == MAX_CHUNKS - 1) begin : g_last
      assign ne = '0;
    end else begin : g_more
      assign ne = ent[g+1];
    end
    ffsa_cell #(.MAX_CHUNKS(MAX_CHUNKS), .INDEX(g)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (cidx),
      .count    (count_r),
      .req      (req_r),
      .prev_ent (pe),
      .next_ent (ne),
      .ent      (ent[g]),
      .fit      (fit_v[g]),
      .need     (need_v[g]),
      .aoff     (aoff_v[g])
    );
    assign match_v[g] = (g < count_r) && (ent[g].kind != KIND_FREE) &&
                        (ent[g].tag == free_id_r);
  end

  // lowest set bit
  function automatic logic [IW:0] first_set(input logic [MAX_CHUNKS-1:0] v);
    logic [IW:0] r;
    r = '0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, i[IW-1:0]};
    end
    return r;
  endfunction

  // selected entry terms
  entry_t        sel_ent, prv_ent, nxt_ent;
  logic [31:0]   sel_need, sel_off, rem;
  logic [IW:0]   pick, hit;
  logic [IW:0]   idx_p1;
  logic          split, pf, nf;

  assign pick     = first_set(fit_v);
  assign hit      = first_set(match_v);
  assign sel_ent  = ent[idx_r];
  assign sel_need = need_v[idx_r];
  assign sel_off  = aoff_v[idx_r];
  assign rem      = sel_ent.size - sel_need;
  assign split    = (rem != '0);
  assign idx_p1   = {1'b0, idx_r} + 1'b1;
  assign prv_ent  = ent[idx_r - 1'b1];
  assign nxt_ent  = ent[idx_p1[IW-1:0]];
  assign pf       = (idx_r != '0) && (prv_ent.kind == KIND_FREE);
  assign nf       = (CW'(idx_p1) < count_r) && (nxt_ent.kind == KIND_FREE);

  // control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    next_tag_nxt  = next_tag_r;
    bytes_nxt     = bytes_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    rs_status_nxt = rs_status_r;
    rs_id_nxt     = rs_id_r;
    rs_off_nxt    = rs_off_r;
    ctl           = '0;
    ctl.op        = COP_NONE;
    ctl.need      = sel_need;
    ctl.kind      = req_r.kind;
    ctl.split     = split;
    ctl.new_off   = sel_ent.off + sel_need;
    ctl.rem       = rem;
    ctl.new_tag   = next_tag_r;
    cidx          = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (in_req_type == REQ_FREE) ? S_FFIND : S_A1;
      end
      S_A1: state_nxt = S_A2;
      S_A2: state_nxt = S_A3;
      S_A3: state_nxt = S_A4;
      S_A4: state_nxt = S_PICK;
      S_PICK: begin
        idx_nxt   = pick[IW-1:0];
        found_nxt = pick[IW] && !bad_r;
        state_nxt = S_ACOMMIT;
      end
      S_ACOMMIT: begin
        rs_id_nxt  = '0;
        rs_off_nxt = '0;
        if (!found_r) begin
          rs_status_nxt = ST_NOFIT;
        end else if (split && (count_r >= MAXC)) begin
          rs_status_nxt = ST_FULL;
        end else begin
          rs_status_nxt = ST_OK;
          rs_id_nxt     = sel_ent.tag;
          rs_off_nxt    = sel_off;
          ctl.op        = COP_ALLOC;
          bytes_nxt     = bytes_r + sel_need;
          if (split) begin
            count_nxt    = count_r + 1'b1;
            next_tag_nxt = next_tag_r + 1'b1;
          end
        end
        state_nxt = S_RESP;
      end
      S_FFIND: begin
        idx_nxt   = hit[IW-1:0];
        found_nxt = hit[IW];
        state_nxt = S_FMARK;
      end
      S_FMARK: begin
        rs_id_nxt  = '0;
        rs_off_nxt = '0;
        if (!found_r) begin
          rs_status_nxt = ST_UNKNOWN;
          state_nxt     = S_RESP;
        end else begin
          rs_status_nxt = ST_OK;
          bytes_nxt     = (bytes_r >= sel_ent.size) ? bytes_r - sel_ent.size : '0;
          ctl.op        = COP_MARK;
          state_nxt     = S_FMERGEP;
        end
      end
      S_FMERGEP: begin
        if (pf) begin
          ctl.op    = COP_REMOVE;
          count_nxt = count_r - 1'b1;
          idx_nxt   = idx_r - 1'b1;
        end
        state_nxt = S_FMERGEN;
      end
      S_FMERGEN: begin
        if (nf) begin
          ctl.op    = COP_REMOVE;
          cidx      = idx_p1[IW-1:0];
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // block size write rebuilds the table; reset does the same
    if (!rst_n || (cfg_we && (cfg_index == CFG_BLOCK_BYTES))) begin
      ctl.op       = COP_RESET;
      ctl.bb       = rst_n ? cfg_wdata : RESET_BLOCK_BYTES;
      count_nxt    = {{(CW-1){1'b0}}, (ctl.bb != '0)};
      next_tag_nxt = 32'd1;
      bytes_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= {{(CW-1){1'b0}}, 1'b1};
      next_tag_r  <= 32'd1;
      bytes_r     <= '0;
      gmask_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      next_tag_r <= next_tag_nxt;
      bytes_r    <= bytes_nxt;
      found_r    <= found_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_BYTES: ;
          CFG_PAGE_GRAN:   gmask_r <= gmask_w[20:0];
          default: ;
        endcase
      end
      if (state_r == S_RESP && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rs_status_r <= rs_status_nxt;
    rs_id_r     <= rs_id_nxt;
    rs_off_r    <= rs_off_nxt;
    req_r.gmask   <= gmask_r;
    req_r.gran_en <= (gmask_r != '0);
    if (in_acc) begin
      req_r.amask <= pow2_mask(in_req_align);
      req_r.bytes <= in_req_bytes;
      req_r.kind  <= in_resource_kind;
      bad_r       <= (in_req_bytes == '0) || (in_resource_kind == KIND_FREE) ||
                     (in_resource_kind > KIND_OPTIMAL);
      free_id_r   <= in_free_id;
    end
    if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
      out_status_r <= rs_status_r;
      out_id_r     <= rs_id_r;
      out_off_r    <= rs_off_r;
      out_used_r   <= bytes_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_alloc_id     = out_id_r;
  assign out_alloc_offset = out_off_r;
  assign out_used_bytes   = out_used_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXC) else $error("chunk count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready) else $error("ready while a transaction is in flight");

  a_unknown_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FMARK && !found_r && !cfg_we) |=> $stable(count_r) && $stable(bytes_r))
    else $error("unknown id changed the table");

  a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACOMMIT && found_r && split && count_r >= MAXC && !cfg_we)
    |=> $stable(count_r) && $stable(next_tag_r)) else $error("full table grew");

endmodule
`default_nettype wire

// File: dv/first_fit_segment_allocator_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit_tb
// Self-checking bench for the first-fit allocator: a directed table of
// requests, then random allocate/free traffic under several block sizes and
// granularities, every result checked against a behavioral chunk table.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit_tb;
  import ffsa_pkg::*;

  localparam int unsigned NCH = DEF_MAX_CHUNKS;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  wire         in_ready;
  logic        in_req_type;
  logic [31:0] in_req_bytes;
  logic [31:0] in_req_align;
  logic [2:0]  in_resource_kind;
  logic [31:0] in_free_id;
  wire         out_valid;
  logic        out_ready;
  wire  [1:0]  out_status;
  wire  [31:0] out_alloc_id;
  wire  [31:0] out_alloc_offset;
  wire  [31:0] out_used_bytes;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;

  first_fit_segment_allocator_unit uut (.*);

  // one request and one answer
  typedef struct {
    logic        rtype;
    logic [31:0] bytes;
    logic [31:0] align;
    logic [2:0]  kind;
    logic [31:0] fid;
  } req_s;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] id;
    logic [31:0] offset;
    logic [31:0] used;
  } ans_s;

  // predictor copy of the chunk table
  logic [31:0] tbl_off  [NCH];
  logic [31:0] tbl_size [NCH];
  logic [2:0]  tbl_kind [NCH];
  logic [31:0] tbl_tag  [NCH];
  int unsigned tbl_cnt;
  logic [31:0] tag_next;
  logic [31:0] in_use;
  logic [31:0] blk_bytes;
  logic [20:0] gran_reg;

  ans_s        pending_answers[$];
  logic [31:0] live_ids[$];   // ids believed allocated, used for frees
  int          errors;
  int          mismatches;
  int          n_ok, n_nofit, n_full, n_unknown;
  bit          tx_idle_en, rx_idle_en;

  function automatic logic [63:0] floor_pow2(input logic [63:0] v);
    logic [63:0] r;
    if (v == 0) return 1;
    r = 1;
    for (int b = 0; b < 64; b++) if (v[b]) r = 64'd1 << b;
    return r;
  endfunction

  function automatic logic [63:0] round_up(input logic [63:0] x, input logic [63:0] a);
    return (x + a - 1) & ~(a - 1);
  endfunction

  function automatic bit share_page(input logic [63:0] a_off, input logic [63:0] a_sz,
                                    input logic [63:0] b_off, input logic [63:0] pg);
    logic [63:0] a_end;
    a_end = a_off + a_sz - 1;
    return (a_end & ~(pg - 1)) == (b_off & ~(pg - 1));
  endfunction

  function automatic bit clash(input logic [2:0] a, input logic [2:0] b);
    logic [2:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case (lo)
      KIND_BUFFER: return hi == KIND_IMAGE || hi == KIND_OPTIMAL;
      KIND_IMAGE:  return hi == KIND_IMAGE || hi == KIND_LINEAR || hi == KIND_OPTIMAL;
      KIND_LINEAR: return hi == KIND_OPTIMAL;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic void table_rebuild();
    for (int k = 0; k < NCH; k++) begin
      tbl_off[k] = 0; tbl_size[k] = 0; tbl_kind[k] = KIND_FREE; tbl_tag[k] = 0;
    end
    tbl_size[0] = blk_bytes;
    tbl_cnt = (blk_bytes != 0) ? 1 : 0;
    tag_next = 1;
    in_use = 0;
    live_ids.delete();
  endfunction

  function automatic void drop_entry(input int unsigned i);
    for (int unsigned j = i; j + 1 < tbl_cnt; j++) begin
      tbl_off[j] = tbl_off[j+1]; tbl_size[j] = tbl_size[j+1];
      tbl_kind[j] = tbl_kind[j+1]; tbl_tag[j] = tbl_tag[j+1];
    end
    tbl_cnt--;
  endfunction

  function automatic ans_s place_chunk(input req_s r);
    ans_s a;
    logic [63:0] g, al, st, o, need, rem;
    a = '{ST_NOFIT, 0, 0, 0};
    g  = floor_pow2(gran_reg);
    al = floor_pow2(r.align);
    if (r.bytes == 0 || r.kind == KIND_FREE || r.kind > KIND_OPTIMAL) return a;
    for (int unsigned i = 0; i < tbl_cnt; i++) begin
      if (tbl_kind[i] != KIND_FREE) continue;
      st = tbl_off[i];
      o = round_up(st, al);
      if (i > 0 && g > 1 && share_page(tbl_off[i-1], tbl_size[i-1], o, g) &&
          clash(tbl_kind[i-1], r.kind))
        o = round_up(o, g);
      need = (o - st) + r.bytes;
      if (need > tbl_size[i]) continue;
      if (g > 1 && i + 1 < tbl_cnt && share_page(o, r.bytes, tbl_off[i+1], g) &&
          clash(r.kind, tbl_kind[i+1]))
        continue;
      rem = tbl_size[i] - need;
      if (rem != 0) begin
        if (tbl_cnt >= NCH) begin
          a.status = ST_FULL;
          return a;
        end
        for (int unsigned j = tbl_cnt; j > i + 1; j--) begin
          tbl_off[j] = tbl_off[j-1]; tbl_size[j] = tbl_size[j-1];
          tbl_kind[j] = tbl_kind[j-1]; tbl_tag[j] = tbl_tag[j-1];
        end
        tbl_off[i+1] = 32'(st + need);
        tbl_size[i+1] = rem[31:0];
        tbl_kind[i+1] = KIND_FREE;
        tbl_tag[i+1] = tag_next;
        tag_next++;
        tbl_cnt++;
      end
      tbl_size[i] = need[31:0];
      tbl_kind[i] = r.kind;
      in_use += need[31:0];
      a.status = ST_OK;
      a.id = tbl_tag[i];
      a.offset = o[31:0];
      return a;
    end
    return a;
  endfunction

  function automatic logic [1:0] release_chunk(input logic [31:0] id);
    int unsigned i;
    for (i = 0; i < tbl_cnt; i++)
      if (tbl_kind[i] != KIND_FREE && tbl_tag[i] == id) break;
    if (i >= tbl_cnt) return ST_UNKNOWN;
    in_use = (in_use >= tbl_size[i]) ? in_use - tbl_size[i] : 0;
    tbl_kind[i] = KIND_FREE;
    if (i > 0 && tbl_kind[i-1] == KIND_FREE) begin
      tbl_size[i-1] += tbl_size[i];
      drop_entry(i);
      i--;
    end
    if (i + 1 < tbl_cnt && tbl_kind[i+1] == KIND_FREE) begin
      tbl_size[i] += tbl_size[i+1];
      drop_entry(i + 1);
    end
    return ST_OK;
  endfunction

  function automatic ans_s predict_answer(input req_s r);
    ans_s a;
    if (r.rtype == REQ_ALLOC) begin
      a = place_chunk(r);
      if (a.status == ST_OK) live_ids.push_back(a.id);
    end else begin
      a = '{release_chunk(r.fid), 0, 0, 0};
      foreach (live_ids[k]) if (live_ids[k] == r.fid) begin
        live_ids.delete(k);
        break;
      end
    end
    a.used = in_use;
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random stall, compare each transaction with the oldest
  // pending answer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle_en && $urandom_range(99) < 13);
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result status=%0d", out_status);
        end else begin
          ans_s e;
          e = pending_answers.pop_front();
          case (e.status)
            ST_OK:      n_ok++;
            ST_NOFIT:   n_nofit++;
            ST_FULL:    n_full++;
            default:    n_unknown++;
          endcase
          if (out_status !== e.status || out_alloc_id !== e.id ||
              out_alloc_offset !== e.offset || out_used_bytes !== e.used) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp st=%0d id=%0d off=%0h used=%0h, got st=%0d id=%0d off=%0h used=%0h",
                       e.status, e.id, e.offset, e.used,
                       out_status, out_alloc_id, out_alloc_offset, out_used_bytes);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // drive one transaction; the predictor runs at the accepting edge
  task automatic send_req(input req_s r, input bit chk_fixed, input ans_s fixed);
    ans_s a;
    while (tx_idle_en && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= r.rtype;
    in_req_bytes     <= r.bytes;
    in_req_align     <= r.align;
    in_resource_kind <= r.kind;
    in_free_id       <= r.fid;
    do @(posedge clk); while (!in_ready);
    a = predict_answer(r);
    if (chk_fixed && (a.status !== fixed.status || a.id !== fixed.id ||
                      a.offset !== fixed.offset || a.used !== fixed.used)) begin
      errors++;
      $display("directed row disagrees with predictor: st=%0d id=%0d", a.status, a.id);
    end
    pending_answers.push_back(a);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_answers.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // no-result work cannot exist (every request answers), allow pipeline slack
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_BYTES) begin
      blk_bytes = v;
      table_rebuild();
    end else begin
      gran_reg = v[20:0];
    end
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_size(input logic [31:0] cap);
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 1;
      default: return $urandom_range((cap > 4) ? cap / 4 : 1, 1);
    endcase
  endfunction

  function automatic req_s rand_req(input logic [31:0] cap);
    req_s r;
    r.rtype = ($urandom_range(99) < 45 && live_ids.size() != 0) ? REQ_FREE : REQ_ALLOC;
    r.bytes = rand_size(cap);
    r.align = ($urandom_range(9) == 0) ? $urandom : 32'd1 << $urandom_range(8);
    r.kind  = ($urandom_range(19) == 0) ? 3'($urandom_range(7))
                                        : 3'($urandom_range(4, 1));
    if (r.rtype == REQ_FREE && $urandom_range(9) != 0)
      r.fid = live_ids[$urandom_range(live_ids.size() - 1)];
    else
      r.fid = ($urandom_range(1)) ? $urandom : tag_next + 3;
    if ($urandom_range(29) == 0) r.bytes = 0;
    return r;
  endfunction

  // directed rows: expected answer typed in where it is obvious
  typedef struct {
    req_s r;
    bit   chk;
    ans_s a;
  } row_s;

  row_s dir_rows[] = '{
    '{'{REQ_ALLOC, 32'd0,     32'd1, KIND_BUFFER, 0},  1, '{ST_NOFIT, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd16,    32'd1, 3'd0,        0},  1, '{ST_NOFIT, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd16,    32'd1, 3'd7,        0},  1, '{ST_NOFIT, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd16,    32'd1, 3'd5,        0},  1, '{ST_NOFIT, 0, 0, 0}},
    '{'{REQ_FREE,  32'd0,     32'd1, KIND_BUFFER, 32'hFFFFFFFF}, 1, '{ST_UNKNOWN, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'hFFFFFFFF, 32'd1, KIND_BUFFER, 0}, 1, '{ST_NOFIT, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd100,   32'd1, KIND_BUFFER, 0},  1, '{ST_OK, 0, 0, 100}},
    '{'{REQ_ALLOC, 32'd10,    32'd0, KIND_IMAGE,  0},  0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd10,    32'd48, KIND_LINEAR, 0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd7,     32'h80000000, KIND_OPTIMAL, 0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd7,     32'hFFFFFFFF, KIND_OPTIMAL, 0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_FREE,  32'd0,     32'd1, KIND_BUFFER, 32'd2}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_FREE,  32'd0,     32'd1, KIND_BUFFER, 32'd0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_FREE,  32'd0,     32'd1, KIND_BUFFER, 32'd1}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_FREE,  32'd0,     32'd1, KIND_BUFFER, 32'd3}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'h10000000, 32'd1, KIND_IMAGE, 0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_FREE,  32'd0,     32'd1, KIND_BUFFER, 32'd0}, 0, '{ST_OK, 0, 0, 0}}
  };

  // granularity scenario rows, run after page granularity is raised
  row_s gran_rows[] = '{
    '{'{REQ_ALLOC, 32'd100, 32'd1, KIND_BUFFER,  0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd100, 32'd1, KIND_IMAGE,   0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd50,  32'd1, KIND_LINEAR,  0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd50,  32'd1, KIND_OPTIMAL, 0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_FREE,  32'd0,   32'd1, KIND_BUFFER,  32'd2}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd20,  32'd1, KIND_IMAGE,   0}, 0, '{ST_OK, 0, 0, 0}},
    '{'{REQ_ALLOC, 32'd20,  32'd1, KIND_BUFFER,  0}, 0, '{ST_OK, 0, 0, 0}}
  };

  // block size and granularity settings for the random phases
  logic [31:0] bb_set[6] = '{32'd268435456, 32'd4096, 32'hFFFFFFFF, 32'd1,
                             32'd65536, 32'd300};
  logic [31:0] gr_set[6] = '{32'd1, 32'd256, 32'h100000, 32'd0, 32'd64, 32'h1FFFFF};

  initial begin
    int n_sent;
    errors = 0; mismatches = 0;
    n_ok = 0; n_nofit = 0; n_full = 0; n_unknown = 0;
    tx_idle_en = 1'b1; rx_idle_en = 1'b1;
    rst_n <= 1'b0;
    in_valid <= 1'b0; in_req_type <= REQ_ALLOC; in_req_bytes <= '0;
    in_req_align <= 32'd1; in_resource_kind <= KIND_BUFFER; in_free_id <= '0;
    cfg_we <= 1'b0; cfg_index <= CFG_BLOCK_BYTES; cfg_wdata <= '0;
    blk_bytes = RESET_BLOCK_BYTES;
    gran_reg = 21'd1;
    table_rebuild();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, bad requests, alignment extremes, merge paths
    foreach (dir_rows[k]) send_req(dir_rows[k].r, dir_rows[k].chk, dir_rows[k].a);
    drain();

    // page conflicts, an empty block, then a small block to hit a full table
    write_reg(CFG_BLOCK_BYTES, 32'd4096);
    write_reg(CFG_PAGE_GRAN, 32'd64);
    foreach (gran_rows[k]) send_req(gran_rows[k].r, 1'b0, gran_rows[k].a);
    drain();
    write_reg(CFG_BLOCK_BYTES, 32'd0);
    send_req('{REQ_ALLOC, 32'd1, 32'd1, KIND_BUFFER, 0}, 1'b1, '{ST_NOFIT, 0, 0, 0});
    drain();
    write_reg(CFG_PAGE_GRAN, 32'd1);
    write_reg(CFG_BLOCK_BYTES, 32'd1000);
    for (int k = 0; k < 70; k++)
      send_req('{REQ_ALLOC, 32'd1, 32'd1, KIND_BUFFER, 0}, 1'b0, '{ST_OK, 0, 0, 0});
    drain();

    // random phases
    n_sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_BLOCK_BYTES, bb_set[ph]);
      write_reg(CFG_PAGE_GRAN, gr_set[ph]);
      tx_idle_en = (ph != 2);
      rx_idle_en = (ph != 2);
      for (int k = 0; k < 225; k++) begin
        send_req(rand_req(blk_bytes), 1'b0, '{ST_OK, 0, 0, 0});
        n_sent++;
        // hold off until the block has answered everything
        if (k == 100) begin
          in_valid <= 1'b0;
          while (pending_answers.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    tx_idle_en = 1'b1; rx_idle_en = 1'b1;
    drain();

    $display("covered %0d random requests over 6 settings plus directed rows", n_sent);
    $display("answers: ok %0d, no fit %0d, table full %0d, unknown id %0d",
             n_ok, n_nofit, n_full, n_unknown);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
